// ===== src/tlc_pkg.sv =====
// ----------------------------------------------------------------------------
// tlc_pkg
// Shared types and constants of the toggle light controller.
// ----------------------------------------------------------------------------
package tlc_pkg;

  localparam int LIGHT_W  = 6;
  localparam int SWITCH_W = 6;
  localparam int DIGIT_W  = 4;
  localparam int BYTE_W   = 8;
  localparam int CFG_IDX_W = 2;
  localparam int FRAME_MAX = 5;

  localparam logic [CFG_IDX_W-1:0] REG_VERSION    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BOARD_TYPE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BOARD_ID   = 2'd2;

  localparam logic [BYTE_W-1:0] CHR_HASH = 8'd35;
  localparam logic [BYTE_W-1:0] CHR_ZERO = 8'd48;
  localparam logic [BYTE_W-1:0] CHR_ONE  = 8'd49;

  localparam logic [BYTE_W-1:0] OPC_OFF      = 8'd48;
  localparam logic [BYTE_W-1:0] OPC_ON       = 8'd49;
  localparam logic [BYTE_W-1:0] OPC_STATUS   = 8'd50;
  localparam logic [BYTE_W-1:0] OPC_VERSION  = 8'd51;
  localparam logic [BYTE_W-1:0] OPC_TYPE     = 8'd52;
  localparam logic [BYTE_W-1:0] OPC_ID       = 8'd53;
  localparam logic [BYTE_W-1:0] OPC_CHANNELS = 8'd55;

  localparam logic [0:0] OP_SWITCH = 1'b0;
  localparam logic [0:0] OP_RX     = 1'b1;

  typedef enum logic [1:0] {
    CMD_NONE,
    CMD_STATUS,
    CMD_NUMBER
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic [DIGIT_W-1:0] value;
  } cmd_t;

endpackage

// ===== src/tlc_front.sv =====
// ----------------------------------------------------------------------------
// tlc_front
// Accepts switch samples and serial bytes, keeps light and frame state and
// classifies each transaction into a reply command with a light snapshot.
// ----------------------------------------------------------------------------
module tlc_front import tlc_pkg::*; #(
  parameter int CHANNELS = 6
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_acc,
  input  logic [0:0]           in_op,
  input  logic [SWITCH_W-1:0]  in_switch_levels,
  input  logic [BYTE_W-1:0]    in_rx_byte,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIGIT_W-1:0]   cfg_wdata,
  output cmd_t                 cmd,
  output logic [CHANNELS-1:0]  cmd_lights
);

  localparam int LW = (CHANNELS > SWITCH_W) ? CHANNELS : SWITCH_W;

  logic [CHANNELS-1:0] light_r, light_nxt;
  logic [CHANNELS-1:0] pressed_r, pressed_nxt;
  logic [2:0]          count_r, count_nxt;
  logic [BYTE_W-1:0]   opcode_r, opcode_nxt;
  logic [BYTE_W-1:0]   channel_r, channel_nxt;
  logic [DIGIT_W-1:0]  version_r, board_type_r, board_id_r;

  logic [LW-1:0]       sw_ext;
  logic [CHANNELS-1:0] levels;
  logic [BYTE_W-1:0]   chan_off;
  logic                frame_ok;
  logic [CHANNELS-1:0] chan_bit;

  always_comb begin
    sw_ext   = LW'(in_switch_levels);
    levels   = sw_ext[CHANNELS-1:0];
    chan_off = channel_r - CHR_ZERO;
    chan_bit = CHANNELS'(1) << chan_off;
    frame_ok = (count_r >= 3'd2) && (channel_r >= CHR_ZERO) &&
               (chan_off < BYTE_W'(CHANNELS));
  end

  always_comb begin
    light_nxt   = light_r;
    pressed_nxt = pressed_r;
    count_nxt   = count_r;
    opcode_nxt  = opcode_r;
    channel_nxt = channel_r;
    cmd.kind    = CMD_NONE;
    cmd.value   = '0;
    if (in_acc) begin
      if (in_op == OP_SWITCH) begin
        light_nxt   = light_r ^ (levels & ~pressed_r);
        pressed_nxt = levels;
      end else if (in_rx_byte == CHR_HASH) begin
        count_nxt = '0;
        if (frame_ok) begin
          unique case (opcode_r)
            OPC_OFF: begin
              light_nxt = light_r & ~chan_bit;
              cmd.kind  = CMD_STATUS;
            end
            OPC_ON: begin
              light_nxt = light_r | chan_bit;
              cmd.kind  = CMD_STATUS;
            end
            OPC_STATUS: cmd.kind = CMD_STATUS;
            OPC_VERSION: begin
              cmd.kind  = CMD_NUMBER;
              cmd.value = version_r;
            end
            OPC_TYPE: begin
              cmd.kind  = CMD_NUMBER;
              cmd.value = board_type_r;
            end
            OPC_ID: begin
              cmd.kind  = CMD_NUMBER;
              cmd.value = board_id_r;
            end
            OPC_CHANNELS: begin
              cmd.kind  = CMD_NUMBER;
              cmd.value = DIGIT_W'(CHANNELS);
            end
            default: cmd.kind = CMD_NONE;
          endcase
        end
      end else if (count_r < 3'(FRAME_MAX)) begin
        if (count_r == 3'd0) begin
          opcode_nxt = in_rx_byte;
        end
        if (count_r == 3'd1) begin
          channel_nxt = in_rx_byte;
        end
        count_nxt = count_r + 3'd1;
      end
    end
    cmd_lights = light_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      light_r      <= '0;
      pressed_r    <= '0;
      count_r      <= '0;
      opcode_r     <= '0;
      channel_r    <= '0;
      version_r    <= DIGIT_W'(1);
      board_type_r <= DIGIT_W'(1);
      board_id_r   <= DIGIT_W'(1);
    end else begin
      light_r   <= light_nxt;
      pressed_r <= pressed_nxt;
      count_r   <= count_nxt;
      opcode_r  <= opcode_nxt;
      channel_r <= channel_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_VERSION:    version_r    <= cfg_wdata;
          REG_BOARD_TYPE: board_type_r <= cfg_wdata;
          REG_BOARD_ID:   board_id_r   <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

endmodule

// ===== src/tlc_fifo.sv =====
// ----------------------------------------------------------------------------
// tlc_fifo
// Short command queue between the front and back parts.
// ----------------------------------------------------------------------------
module tlc_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [AW:0]      count_r;
  logic             do_push, do_pop;

  assign full    = (count_r == (AW+1)'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH-1)) ? '0 : wr_ptr_r + AW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH-1)) ? '0 : rd_ptr_r + AW'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + (AW+1)'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - (AW+1)'(1);
      end
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= (AW+1)'(DEPTH))
    else $error("queue count beyond depth");

  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (do_push && !do_pop) |=> (count_r == $past(count_r) + (AW+1)'(1)))
    else $error("push did not grow queue");

  a_pop_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    (do_pop && !do_push) |=> (count_r == $past(count_r) - (AW+1)'(1)))
    else $error("pop did not shrink queue");
`endif

endmodule

// ===== src/tlc_back.sv =====
// ----------------------------------------------------------------------------
// tlc_back
// Expands queued commands into reply bytes and holds the result register.
// ----------------------------------------------------------------------------
module tlc_back import tlc_pkg::*; #(
  parameter int CHANNELS = 6
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_empty,
  input  cmd_t                q_cmd,
  input  logic [CHANNELS-1:0] q_lights,
  output logic                q_pop,
  output logic                empty,
  input  logic                pop,
  output logic [LIGHT_W-1:0]  out_light_mask,
  output logic [BYTE_W-1:0]   out_tx_byte,
  output logic                out_tx_valid,
  output logic                out_last
);

  localparam int IW  = $clog2(CHANNELS * 4 + 1);
  localparam int LW  = (CHANNELS > LIGHT_W) ? CHANNELS : LIGHT_W;

  logic                cur_valid_r;
  cmd_t                cur_cmd_r;
  logic [CHANNELS-1:0] cur_lights_r;
  logic [IW-1:0]       idx_r;

  logic                out_valid_r;
  logic [LIGHT_W-1:0]  mask_r;
  logic [BYTE_W-1:0]   byte_r;
  logic                bvalid_r;
  logic                last_r;

  logic                out_free, emit, done;
  logic [BYTE_W-1:0]   gen_byte;
  logic                gen_valid, gen_last;
  logic                light_bit;
  logic [DIGIT_W-1:0]  low_digit;
  logic                two_digits;
  logic [LW-1:0]       lights_ext;

  always_comb begin
    light_bit  = |((cur_lights_r >> (idx_r >> 2)) & CHANNELS'(1));
    two_digits = (cur_cmd_r.value >= DIGIT_W'(10));
    low_digit  = two_digits ? cur_cmd_r.value - DIGIT_W'(10) : cur_cmd_r.value;
    gen_byte   = '0;
    gen_valid  = 1'b1;
    gen_last   = 1'b0;
    unique case (cur_cmd_r.kind)
      CMD_STATUS: begin
        if (idx_r == IW'(CHANNELS * 4)) begin
          gen_byte = CHR_HASH;
          gen_last = 1'b1;
        end else if (idx_r[1:0] == 2'd0) begin
          gen_byte = CHR_ZERO + BYTE_W'(light_bit);
        end else begin
          gen_byte = CHR_ZERO;
        end
      end
      CMD_NUMBER: begin
        if (two_digits && idx_r == '0) begin
          gen_byte = CHR_ONE;
        end else if (idx_r == IW'(two_digits)) begin
          gen_byte = CHR_ZERO + BYTE_W'(low_digit);
        end else begin
          gen_byte = CHR_HASH;
          gen_last = 1'b1;
        end
      end
      default: begin
        gen_valid = 1'b0;
        gen_last  = 1'b1;
      end
    endcase
  end

  assign out_free = !out_valid_r || pop;
  assign emit     = out_free && cur_valid_r;
  assign done     = emit && gen_last;
  assign q_pop    = !q_empty && (!cur_valid_r || done);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      idx_r       <= '0;
    end else if (q_pop) begin
      cur_valid_r <= 1'b1;
      idx_r       <= '0;
    end else if (done) begin
      cur_valid_r <= 1'b0;
    end else if (emit) begin
      idx_r <= idx_r + IW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_cmd_r    <= q_cmd;
      cur_lights_r <= q_lights;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= cur_valid_r;
    end
  end

  assign lights_ext = LW'(cur_lights_r);

  always_ff @(posedge clk) begin
    if (emit) begin
      mask_r   <= lights_ext[LIGHT_W-1:0];
      byte_r   <= gen_byte;
      bvalid_r <= gen_valid;
      last_r   <= gen_last;
    end
  end

  assign empty          = !out_valid_r;
  assign out_light_mask = mask_r;
  assign out_tx_byte    = byte_r;
  assign out_tx_valid   = bvalid_r;
  assign out_last       = last_r;

endmodule

// ===== src/toggle_light_controller.sv =====
// ----------------------------------------------------------------------------
// toggle_light_controller
// Light controller driven by switch samples and serial command frames.
//
// Channel  | Handshake       | Payload
// input    | push / full     | in_op, in_switch_levels, in_rx_byte
// result   | empty / pop     | out_light_mask, out_tx_byte, out_tx_valid, out_last
// config   | cfg_we          | cfg_index, cfg_wdata
//
// One input transaction is taken per cycle while the command queue has room.
// Results leave one per cycle while the receiver pops; a status reply is CHANNELS*4+1
// result transactions, a number reply two or three, anything else one.
// The four-entry command queue parts the front from the reply sequencer.
// Reset is synchronous; it clears lights, frame state and queue, and sets the
// digit registers to one.
// ----------------------------------------------------------------------------
module toggle_light_controller import tlc_pkg::*; #(
  parameter int CHANNELS = 6
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  output logic                 full,
  input  logic [0:0]           in_op,
  input  logic [SWITCH_W-1:0]  in_switch_levels,
  input  logic [BYTE_W-1:0]    in_rx_byte,
  output logic                 empty,
  input  logic                 pop,
  output logic [LIGHT_W-1:0]   out_light_mask,
  output logic [BYTE_W-1:0]    out_tx_byte,
  output logic                 out_tx_valid,
  output logic                 out_last,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIGIT_W-1:0]   cfg_wdata
);

  localparam int QW = $bits(cmd_t) + CHANNELS;

  logic                in_acc;
  cmd_t                f_cmd, q_cmd;
  logic [CHANNELS-1:0] f_lights, q_lights;
  logic                q_empty, q_pop;

  assign in_acc = push && !full;

  tlc_front #(.CHANNELS(CHANNELS)) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_acc           (in_acc),
    .in_op            (in_op),
    .in_switch_levels (in_switch_levels),
    .in_rx_byte       (in_rx_byte),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .cmd              (f_cmd),
    .cmd_lights       (f_lights)
  );

  tlc_fifo #(.WIDTH(QW), .DEPTH(4)) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_acc),
    .wdata ({f_cmd, f_lights}),
    .full  (full),
    .pop   (q_pop),
    .rdata ({q_cmd, q_lights}),
    .empty (q_empty)
  );

  tlc_back #(.CHANNELS(CHANNELS)) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_empty        (q_empty),
    .q_cmd          (q_cmd),
    .q_lights       (q_lights),
    .q_pop          (q_pop),
    .empty          (empty),
    .pop            (pop),
    .out_light_mask (out_light_mask),
    .out_tx_byte    (out_tx_byte),
    .out_tx_valid   (out_tx_valid),
    .out_last       (out_last)
  );

endmodule

// ===== tb/tb_toggle_light_controller.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_toggle_light_controller
// Self-checking bench for the toggle light controller. A queue of switch
// samples and serial bytes feeds a driver; a monitor tracks the light state,
// the frame collector and the digit registers. For every input transaction
// it queues the expected light mask and reply bytes, and it compares each
// result transaction with the oldest one. A directed group of frames comes
// first, then mostly well-formed random frames mixed with switch samples and
// stray bytes. Each phase after the first writes its own set of digit registers,
// and both ports stall at random in every phase but the third.
// ----------------------------------------------------------------------------
module tb_toggle_light_controller import tlc_pkg::*; ;

  localparam int NUM_CH         = 6;
  localparam int N_PHASES       = 5;
  localparam int RAND_PER_PHASE = 79;
  localparam int DRAIN_LIMIT    = 20000;

  typedef struct packed {
    logic [0:0]          op;
    logic [SWITCH_W-1:0] levels;
    logic [BYTE_W-1:0]   rx;
  } light_input_t;

  typedef struct packed {
    logic [LIGHT_W-1:0] mask;
    logic [BYTE_W-1:0]  tx;
    logic               valid;
    logic               last;
  } light_result_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 push = 1'b0;
  logic                 full;
  logic [0:0]           in_op = OP_SWITCH;
  logic [SWITCH_W-1:0]  in_switch_levels = '0;
  logic [BYTE_W-1:0]    in_rx_byte = '0;
  logic                 empty;
  logic                 pop = 1'b0;
  logic [LIGHT_W-1:0]   out_light_mask;
  logic [BYTE_W-1:0]    out_tx_byte;
  logic                 out_tx_valid;
  logic                 out_last;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_VERSION;
  logic [DIGIT_W-1:0]   cfg_wdata = '0;

  light_input_t  pending_items[$];
  light_result_t expected_results[$];
  logic [BYTE_W-1:0] reply_bytes[$];
  logic [BYTE_W-1:0] opcode_set [7] = '{OPC_OFF, OPC_ON, OPC_STATUS, OPC_VERSION,
                                        OPC_TYPE, OPC_ID, OPC_CHANNELS};

  // controller state as predicted
  logic [LIGHT_W-1:0]  lights = '0;
  logic [SWITCH_W-1:0] pressed_lv = '0;
  int                  frame_len = 0;
  logic [BYTE_W-1:0]   frame_opc = '0;
  logic [BYTE_W-1:0]   frame_chan = '0;
  logic [DIGIT_W-1:0]  cfg_version = 4'd1;
  logic [DIGIT_W-1:0]  cfg_board_type = 4'd1;
  logic [DIGIT_W-1:0]  cfg_board_id = 4'd1;

  light_input_t  next_item;
  light_result_t oldest;
  bit            no_idle = 1'b0;
  int            send_gap = 0;
  int            recv_gap = 0;
  int            n_fail = 0;
  int            n_in = 0;
  int            n_out = 0;
  int            n_replies = 0;
  int            n_settings = 1;

  toggle_light_controller #(
    .CHANNELS(NUM_CH)
  ) u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .push             (push),
    .full             (full),
    .in_op            (in_op),
    .in_switch_levels (in_switch_levels),
    .in_rx_byte       (in_rx_byte),
    .empty            (empty),
    .pop              (pop),
    .out_light_mask   (out_light_mask),
    .out_tx_byte      (out_tx_byte),
    .out_tx_valid     (out_tx_valid),
    .out_last         (out_last),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic void predict_controller(logic [0:0] op, logic [SWITCH_W-1:0] levels,
                                             logic [BYTE_W-1:0] rx);
    logic [BYTE_W-1:0] chan_idx;
    int num;
    light_result_t res;
    reply_bytes.delete();
    num = -1;
    if (op == OP_SWITCH) begin
      lights = lights ^ (levels & ~pressed_lv);
      pressed_lv = levels;
    end else if (rx == CHR_HASH) begin
      chan_idx = frame_chan - CHR_ZERO;
      if (frame_len >= 2 && frame_chan >= CHR_ZERO && chan_idx < BYTE_W'(NUM_CH)) begin
        case (frame_opc)
          OPC_OFF, OPC_ON, OPC_STATUS: begin
            if (frame_opc == OPC_OFF) lights[chan_idx] = 1'b0;
            if (frame_opc == OPC_ON) lights[chan_idx] = 1'b1;
            for (int i = 0; i < NUM_CH; i++) begin
              reply_bytes.push_back(CHR_ZERO + lights[i]);
              repeat (3) reply_bytes.push_back(CHR_ZERO);
            end
            reply_bytes.push_back(CHR_HASH);
          end
          OPC_VERSION:  num = cfg_version;
          OPC_TYPE:     num = cfg_board_type;
          OPC_ID:       num = cfg_board_id;
          OPC_CHANNELS: num = NUM_CH;
          default: ;
        endcase
        if (num >= 0) begin
          if (num >= 10) begin
            reply_bytes.push_back(CHR_ONE);
            num = num - 10;
          end
          reply_bytes.push_back(CHR_ZERO + BYTE_W'(num));
          reply_bytes.push_back(CHR_HASH);
        end
      end
      frame_len = 0;
    end else if (frame_len < FRAME_MAX) begin
      if (frame_len == 0) frame_opc = rx;
      else if (frame_len == 1) frame_chan = rx;
      frame_len++;
    end
    if (reply_bytes.size() == 0) begin
      res = '{mask: lights, tx: '0, valid: 1'b0, last: 1'b1};
      expected_results.push_back(res);
    end else begin
      n_replies++;
      foreach (reply_bytes[k]) begin
        res = '{mask: lights, tx: reply_bytes[k], valid: 1'b1,
                last: (k == reply_bytes.size() - 1)};
        expected_results.push_back(res);
      end
    end
  endfunction

  function automatic logic [BYTE_W-1:0] non_hash_byte();
    logic [BYTE_W-1:0] b;
    do b = BYTE_W'($urandom_range(0, 255)); while (b == CHR_HASH);
    return b;
  endfunction

  function automatic void add_switch(logic [SWITCH_W-1:0] levels);
    light_input_t it;
    it = '{op: OP_SWITCH, levels: levels, rx: BYTE_W'($urandom_range(0, 255))};
    pending_items.push_back(it);
  endfunction

  function automatic void add_rx(logic [BYTE_W-1:0] b);
    light_input_t it;
    it = '{op: OP_RX, levels: SWITCH_W'($urandom_range(0, 63)), rx: b};
    pending_items.push_back(it);
  endfunction

  function automatic void add_frame(logic [BYTE_W-1:0] opc, logic [BYTE_W-1:0] chan);
    add_rx(opc);
    add_rx(chan);
    add_rx(CHR_HASH);
  endfunction

  // mostly well-formed frames, some switch samples, some stray bytes
  function automatic void add_random(int n);
    int added;
    int r;
    int extra;
    logic [BYTE_W-1:0] opc;
    logic [BYTE_W-1:0] chan;
    added = 0;
    while (added < n) begin
      r = $urandom_range(0, 99);
      if (r < 20) begin
        add_switch(SWITCH_W'($urandom_range(0, 63)));
        added++;
      end else if (r < 85) begin
        opc = ($urandom_range(0, 9) == 0) ? non_hash_byte() : opcode_set[$urandom_range(0, 6)];
        chan = ($urandom_range(0, 7) == 0) ? non_hash_byte()
                                           : CHR_ZERO + BYTE_W'($urandom_range(0, NUM_CH - 1));
        extra = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 4) : 0;
        add_rx(opc);
        add_rx(chan);
        repeat (extra) add_rx(non_hash_byte());
        add_rx(CHR_HASH);
        added += 3 + extra;
      end else begin
        add_rx(BYTE_W'($urandom_range(0, 255)));
        added++;
      end
    end
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DIGIT_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_VERSION:    cfg_version = val;
      REG_BOARD_TYPE: cfg_board_type = val;
      REG_BOARD_ID:   cfg_board_id = val;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic write_settings(logic [DIGIT_W-1:0] ver, logic [DIGIT_W-1:0] btype,
                                logic [DIGIT_W-1:0] bid);
    write_reg(REG_VERSION, ver);
    write_reg(REG_BOARD_TYPE, btype);
    write_reg(REG_BOARD_ID, bid);
    n_settings++;
  endtask

  // hold until every queued item is sent and every reply has drained
  task automatic wait_idle();
    int waited;
    waited = 0;
    while ((pending_items.size() > 0 || push || expected_results.size() > 0)
           && waited < DRAIN_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    if (pending_items.size() > 0 || push || expected_results.size() > 0) begin
      $error("drain stalled: %0d items unsent, %0d results outstanding",
             pending_items.size(), expected_results.size());
      n_fail++;
      expected_results.delete();
    end
    repeat (8) @(negedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      push <= 1'b0;
      send_gap = 0;
    end else if (!push || !full) begin
      if (send_gap > 0) begin
        push <= 1'b0;
        send_gap = send_gap - 1;
      end else if (pending_items.size() > 0) begin
        next_item = pending_items.pop_front();
        push             <= 1'b1;
        in_op            <= next_item.op;
        in_switch_levels <= next_item.levels;
        in_rx_byte       <= next_item.rx;
        send_gap = no_idle ? 0 : $urandom_range(0, 3);
      end else begin
        push <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
      recv_gap = 0;
    end else begin
      if (push && !full) begin
        predict_controller(in_op, in_switch_levels, in_rx_byte);
        n_in++;
      end
      if (pop && !empty) begin
        n_out++;
        if (expected_results.size() == 0) begin
          $error("result transaction with nothing expected: tx_byte %0h", out_tx_byte);
          n_fail++;
        end else begin
          oldest = expected_results.pop_front();
          if (out_light_mask !== oldest.mask) begin
            $error("light_mask: expected %0h, got %0h", oldest.mask, out_light_mask);
            n_fail++;
          end
          if (out_tx_byte !== oldest.tx) begin
            $error("tx_byte: expected %0h, got %0h", oldest.tx, out_tx_byte);
            n_fail++;
          end
          if (out_tx_valid !== oldest.valid) begin
            $error("tx_valid: expected %0b, got %0b", oldest.valid, out_tx_valid);
            n_fail++;
          end
          if (out_last !== oldest.last) begin
            $error("last: expected %0b, got %0b", oldest.last, out_last);
            n_fail++;
          end
        end
        recv_gap = no_idle ? 0 : $urandom_range(0, 3);
      end
      if (recv_gap > 0) begin
        pop <= 1'b0;
        recv_gap = recv_gap - 1;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  initial begin
    int ph;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    add_switch(6'h3F);
    add_switch(6'h00);
    add_frame(OPC_ON, CHR_ZERO);
    add_frame(OPC_OFF, CHR_ZERO + 8'd5);
    // overlong frame: bytes past the fifth are dropped
    add_rx(OPC_STATUS);
    add_rx(CHR_ZERO + 8'd3);
    add_rx(8'hFF);
    add_rx(8'h00);
    add_rx(8'h80);
    add_rx(8'h7F);
    add_rx(CHR_HASH);
    add_frame(OPC_CHANNELS, CHR_ZERO);
    add_rx(CHR_HASH);
    add_frame(8'hFF, CHR_ZERO);
    add_frame(OPC_VERSION, CHR_ZERO + 8'd6);
    add_random(RAND_PER_PHASE);
    wait_idle();

    for (ph = 1; ph < N_PHASES; ph++) begin
      case (ph)
        1: write_settings(4'd0, 4'd9, 4'd15);
        2: write_settings(4'd15, 4'd0, 4'd10);
        3: write_settings(4'd9, 4'd12, 4'd0);
        default: write_settings(DIGIT_W'($urandom_range(0, 15)),
                                DIGIT_W'($urandom_range(0, 15)),
                                DIGIT_W'($urandom_range(0, 15)));
      endcase
      no_idle = (ph == 2);
      @(negedge clk);
      add_random(RAND_PER_PHASE);
      wait_idle();
    end

    repeat (40) @(posedge clk);
    $display("%0d input and %0d result transactions under %0d register settings",
             n_in, n_out, n_settings);
    $display("%0d command frames answered with a reply", n_replies);
    if (n_fail == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

endmodule

// ===== filelist.f =====
src/tlc_pkg.sv
src/tlc_front.sv
src/tlc_fifo.sv
src/tlc_back.sv
src/toggle_light_controller.sv
tb/tb_toggle_light_controller.sv
